@@ src/page_table_first_free_frame_alloc_defines.svh @@
// Assertion macros for the page table frame allocator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PAGE_TABLE_FIRST_FREE_FRAME_ALLOC_DEFINES_SVH
`define PAGE_TABLE_FIRST_FREE_FRAME_ALLOC_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define PTFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define PTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTFF_ASSERT_IMPL(lbl, ante, cons, msg)
`define PTFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/ptff_pkg.sv @@
// Shared types and constants for the page table frame allocator.
// No dependencies.
package ptff_pkg;

  localparam int unsigned PAGES       = 128;
  localparam int unsigned PAGE_W      = $clog2(PAGES);
  localparam int unsigned FRAMES      = 128;
  localparam int unsigned FRAME_W     = 7;
  localparam int unsigned FRAME_CNT_W = 8;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RST = FRAME_CNT_W'(128);
  localparam logic [FRAME_CNT_W-1:0] FRAMES_LIMIT    = FRAME_CNT_W'(FRAMES);
  localparam logic [CNT_W-1:0]       CNT_MAX         = '1;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_ALLOC   = 2'd1,
    OUT_NOFRAME = 2'd2
  } outcome_e;

endpackage

@@ src/page_table_first_free_frame_alloc.sv @@
// Demand-paging page table with first-free frame allocation and no replacement.
// Each reference first takes a registered read of the page-to-frame RAM, then
// decides hit or fault, writes the RAM back and loads the output register. A
// new reference is taken as soon as the previous one has moved into the output
// register, even while that result waits; a decided result is held, and no new
// reference is taken, while the output register is still full. Valid bits reset
// in flops, so no clearing pass follows reset. Depends on ptff_pkg, ptff_cfg,
// ptff_frame_ram and the assertion macro header.
`include "page_table_first_free_frame_alloc_defines.svh"

module page_table_first_free_frame_alloc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input word: [6:0] page_index, [7] zero
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ptff_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // output word: [1:0] outcome, [8:2] frame_index, [24:9] faults_seen,
  // [40:25] references_seen, [47:41] zero
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ptff_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ptff_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [ptff_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ptff_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  logic [ptff_pkg::FRAME_CNT_W-1:0] frame_count;
  logic [ptff_pkg::FRAME_CNT_W-1:0] limit;

  logic                              busy_q, busy_d;
  logic [ptff_pkg::PAGE_W-1:0]       page_q;
  logic [ptff_pkg::PAGES-1:0]        valid_q, valid_d;
  // Frames are never released, so the in-use map is always the prefix
  // [0, frames_used); frames_used is also the lowest free frame.
  logic [ptff_pkg::FRAME_CNT_W-1:0]  frames_used_q, frames_used_d;
  logic [ptff_pkg::CNT_W-1:0]        fault_cnt_q, fault_cnt_d;
  logic [ptff_pkg::CNT_W-1:0]        ref_cnt_q, ref_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [ptff_pkg::OUT_TDATA_W-1:0]  out_data_q, out_data_d;

  logic                              s_fire, m_fire, commit;
  logic                              hit, can_alloc, do_alloc;
  logic [ptff_pkg::FRAME_W-1:0]      ram_rdata;
  logic [ptff_pkg::FRAME_W-1:0]      frame_sel;
  ptff_pkg::outcome_e                outcome;

  ptff_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_count_o (frame_count)
  );

  ptff_frame_ram #(
    .DEPTH (ptff_pkg::PAGES),
    .WIDTH (ptff_pkg::FRAME_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (do_alloc),
    .waddr_i (page_q),
    .wdata_i (frames_used_q[ptff_pkg::FRAME_W-1:0]),
    .re_i    (s_fire),
    .raddr_i (s_axis_tdata[ptff_pkg::PAGE_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_valid_q && m_axis_tready;
  assign commit        = busy_q && (!out_valid_q || m_axis_tready);

  assign limit     = (frame_count > ptff_pkg::FRAMES_LIMIT) ? ptff_pkg::FRAMES_LIMIT
                                                            : frame_count;
  assign hit       = valid_q[page_q];
  assign can_alloc = frames_used_q < limit;
  assign do_alloc  = commit && !hit && can_alloc;

  always_comb begin
    if (hit) begin
      outcome   = ptff_pkg::OUT_HIT;
      frame_sel = ram_rdata;
    end else if (can_alloc) begin
      outcome   = ptff_pkg::OUT_ALLOC;
      frame_sel = frames_used_q[ptff_pkg::FRAME_W-1:0];
    end else begin
      outcome   = ptff_pkg::OUT_NOFRAME;
      frame_sel = '0;
    end
  end

  always_comb begin
    busy_d        = busy_q;
    valid_d       = valid_q;
    frames_used_d = frames_used_q;
    fault_cnt_d   = fault_cnt_q;
    ref_cnt_d     = ref_cnt_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;

    if (m_fire) begin
      out_valid_d = 1'b0;
    end
    if (s_fire) begin
      busy_d = 1'b1;
    end
    if (commit) begin
      busy_d = 1'b0;
      if (ref_cnt_q != ptff_pkg::CNT_MAX) begin
        ref_cnt_d = ref_cnt_q + 1'b1;
      end
      if (!hit && (fault_cnt_q != ptff_pkg::CNT_MAX)) begin
        fault_cnt_d = fault_cnt_q + 1'b1;
      end
      if (do_alloc) begin
        valid_d[page_q] = 1'b1;
        frames_used_d   = frames_used_q + 1'b1;
      end
      out_valid_d = 1'b1;
      out_data_d  = {7'b0, ref_cnt_d, fault_cnt_d, frame_sel, outcome};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      valid_q       <= '0;
      frames_used_q <= '0;
      fault_cnt_q   <= '0;
      ref_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      valid_q       <= valid_d;
      frames_used_q <= frames_used_d;
      fault_cnt_q   <= fault_cnt_d;
      ref_cnt_q     <= ref_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      page_q <= s_axis_tdata[ptff_pkg::PAGE_W-1:0];
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PTFF_ASSERT_IMPL(a_frames_bounded, 1'b1, frames_used_q <= ptff_pkg::FRAMES_LIMIT, "frames used beyond frame store")
  `PTFF_ASSERT_NEXT(a_alloc_advances, do_alloc, frames_used_q == $past(frames_used_q) + 1'b1, "allocation did not advance free frame")
  `PTFF_ASSERT_NEXT(a_ref_counts, commit && (ref_cnt_q != ptff_pkg::CNT_MAX), ref_cnt_q == $past(ref_cnt_q) + 1'b1, "reference count missed")
  `PTFF_ASSERT_NEXT(a_accept_busy, s_fire, busy_q && !s_axis_tready, "reference accepted while lookup pending")

endmodule

@@ src/ptff_frame_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the page-to-frame table; no package dependency.
module ptff_frame_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ptff_cfg.sv @@
// APB register block holding the usable frame count.
// Depends on ptff_pkg.
module ptff_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptff_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ptff_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ptff_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [ptff_pkg::FRAME_CNT_W-1:0]    frame_count_o
);

  logic [ptff_pkg::FRAME_CNT_W-1:0] frame_count_q, frame_count_d;
  logic                             sel_frame_count;

  assign pready          = 1'b1;
  assign sel_frame_count = (paddr[2] == ptff_pkg::REG_FRAME_COUNT);

  always_comb begin
    frame_count_d = frame_count_q;
    if (psel && penable && pwrite && pready && sel_frame_count) begin
      frame_count_d = pwdata[ptff_pkg::FRAME_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= ptff_pkg::FRAME_COUNT_RST;
    end else begin
      frame_count_q <= frame_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_frame_count) begin
      prdata = ptff_pkg::APB_DATA_W'(frame_count_q);
    end
  end

  assign frame_count_o = frame_count_q;

endmodule

@@ dv/page_table_first_free_frame_alloc_tb.sv @@
// Self-checking bench for page_table_first_free_frame_alloc: drives page references
// over the input stream and frame_count over APB, and checks every result word.
// Depends on ptff_pkg and the DUT only.
module page_table_first_free_frame_alloc_tb;

  localparam logic [ptff_pkg::APB_ADDR_W-1:0] ADDR_FRAME_COUNT = 3'd0;
  localparam logic [ptff_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;  // index 1, not a register
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;

  // output word layout, lowest field last
  typedef struct packed {
    logic [6:0]                   pad;
    logic [ptff_pkg::CNT_W-1:0]   refs;
    logic [ptff_pkg::CNT_W-1:0]   faults;
    logic [ptff_pkg::FRAME_W-1:0] frame;
    ptff_pkg::outcome_e           outcome;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ptff_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;   // [6:0] page_index, [7] zero
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ptff_pkg::OUT_TDATA_W-1:0] m_axis_tdata;      // [1:0] outcome, [8:2] frame_index,
                                                       // [24:9] faults_seen,
                                                       // [40:25] references_seen
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ptff_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ptff_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ptff_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  page_table_first_free_frame_alloc dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow page table
  bit                               pg_valid [ptff_pkg::PAGES];
  logic [ptff_pkg::FRAME_W-1:0]     pg_frame [ptff_pkg::PAGES];
  bit                               frm_busy [ptff_pkg::FRAMES];
  logic [ptff_pkg::FRAME_CNT_W-1:0] frame_count_q = ptff_pkg::FRAME_COUNT_RST;
  logic [ptff_pkg::CNT_W-1:0]       fault_cnt = '0;
  logic [ptff_pkg::CNT_W-1:0]       ref_cnt = '0;

  logic [ptff_pkg::PAGE_W-1:0] page_q [$];    // references not yet taken by the DUT
  lookup_t                     lookup_q [$];  // predicted results in order

  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  word_taken = 1'b0;
  int  err_cnt = 0;
  int  n_hit = 0, n_alloc = 0, n_noframe = 0;
  int  quiet_cycles = 0;

  function automatic lookup_t translate(logic [ptff_pkg::PAGE_W-1:0] page);
    lookup_t     r;
    int unsigned lim;
    bit          found;
    r = '0;
    found = 1'b0;
    if (ref_cnt != ptff_pkg::CNT_MAX) ref_cnt++;
    if (pg_valid[page]) begin
      r.outcome = ptff_pkg::OUT_HIT;
      r.frame = pg_frame[page];
    end else begin
      if (fault_cnt != ptff_pkg::CNT_MAX) fault_cnt++;
      lim = (frame_count_q < ptff_pkg::FRAMES_LIMIT) ? frame_count_q : ptff_pkg::FRAMES;
      for (int f = 0; f < lim; f++) begin
        if (!found && !frm_busy[f]) begin
          found = 1'b1;
          r.frame = ptff_pkg::FRAME_W'(f);
        end
      end
      if (found) begin
        frm_busy[r.frame] = 1'b1;
        pg_valid[page] = 1'b1;
        pg_frame[page] = r.frame;
        r.outcome = ptff_pkg::OUT_ALLOC;
      end else begin
        r.outcome = ptff_pkg::OUT_NOFRAME;
      end
    end
    r.faults = fault_cnt;
    r.refs = ref_cnt;
    return r;
  endfunction

  function automatic void note_error(string why, lookup_t want, lookup_t got);
    err_cnt++;
    if (err_cnt <= SHOWN_ERRORS)
      $display("%0t %s: exp outcome=%0d frame=%0d faults=%0d refs=%0d pad=%0h | %s",
               $time, why, want.outcome, want.frame, want.faults, want.refs, want.pad,
               $sformatf("got outcome=%0d frame=%0d faults=%0d refs=%0d pad=%0h",
                         got.outcome, got.frame, got.faults, got.refs, got.pad));
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || word_taken) begin
      if (page_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, page_q[0]};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      lookup_q.push_back(translate(s_axis_tdata[ptff_pkg::PAGE_W-1:0]));
      void'(page_q.pop_front());
      word_taken = 1'b1;
    end
  end

  // monitor
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk_i) begin : mon
    lookup_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lookup_t'(m_axis_tdata);
      if (lookup_q.size() == 0) begin
        note_error("unexpected word", '0, got);
      end else begin
        want = lookup_q.pop_front();
        if (got.outcome != want.outcome || got.frame != want.frame ||
            got.faults != want.faults || got.refs != want.refs || got.pad != want.pad)
          note_error("mismatch", want, got);
        unique case (want.outcome)
          ptff_pkg::OUT_HIT:   n_hit++;
          ptff_pkg::OUT_ALLOC: n_alloc++;
          default:             n_noframe++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // sender holds off here until every outstanding lookup has come back
  task automatic drain();
    while (page_q.size() != 0 || lookup_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ptff_pkg::APB_ADDR_W-1:0] addr,
                           input logic [ptff_pkg::APB_DATA_W-1:0] data);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_FRAME_COUNT) frame_count_q = data[ptff_pkg::FRAME_CNT_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly a hot window of pages so hits mix with faults; page 127 kept invalid
  task automatic random_phase(input logic [ptff_pkg::FRAME_CNT_W-1:0] fc, input int src_pct,
                              input int snk_pct, input int n);
    int unsigned base;
    write_reg(ADDR_FRAME_COUNT, ($urandom & 32'hFFFF_FF00) | fc);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    base = $urandom_range(110);
    repeat (n)
      page_q.push_back(ptff_pkg::PAGE_W'(($urandom_range(99) < 60) ? base + $urandom_range(15)
                                                                   : $urandom_range(126)));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset frame count, then zero frames, write to an unused address
    page_q.push_back(7'd2);
    write_reg(ADDR_FRAME_COUNT, 32'd0);
    write_reg(ADDR_UNMAPPED, '1);
    page_q.push_back(7'd127);
    page_q.push_back(7'd0);
    write_reg(ADDR_FRAME_COUNT, 32'd2);
    page_q.push_back(7'd0);
    page_q.push_back(7'd0);
    page_q.push_back(7'd1);
    page_q.push_back(7'd0);
    write_reg(ADDR_FRAME_COUNT, 32'd3);
    page_q.push_back(7'd1);
    page_q.push_back(7'd126);
    page_q.push_back(7'd64);
    page_q.push_back(7'd126);
    page_q.push_back(7'd1);
    // count above FRAMES clamps
    write_reg(ADDR_FRAME_COUNT, 32'd255);
    page_q.push_back(7'd85);
    page_q.push_back(7'd42);
    page_q.push_back(7'd85);

    random_phase(8'd8,   0,  0,  105);
    random_phase(8'd40,  49, 0,  105);
    random_phase(8'd0,   0,  49, 105);
    random_phase(8'd100, 17, 17, 105);
    random_phase(8'd128, 49, 0,  105);
    random_phase(8'd129, 0,  49, 105);

    write_reg(ADDR_FRAME_COUNT, 32'd255);
    src_idle_pct = 17;
    snk_stall_pct = 17;
    page_q.push_back(7'd127);
    page_q.push_back(7'd127);
    repeat (8) page_q.push_back(ptff_pkg::PAGE_W'($urandom_range(127)));

    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d references: %0d hits, %0d allocations, %0d faults without a frame",
             n_hit + n_alloc + n_noframe, n_hit, n_alloc, n_noframe);
    $display("frame counts 0 to 255 with clamping, unused address write, %0s",
             "idle and stall mixes on both sides");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
